@@ rtl/une_pkg.sv @@
// ----------------------------------------------------------------------------
// une_pkg
// Types, constants and helpers shared by the name hex escaper.
// ----------------------------------------------------------------------------
package une_pkg;

    localparam int unsigned ESC_LEN = 6;
    localparam int unsigned IDX_W   = $clog2(ESC_LEN);

    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_NUL        = 8'h00;

    localparam logic [16:0] MAX_KEY_SIZE_RST = 17'd4096;
    localparam logic        UTF8_MODE_RST    = 1'b1;

    localparam logic REG_MAX_KEY_SIZE = 1'b0;
    localparam logic REG_UTF8_MODE    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_MULTIBYTE = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_ESC  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [16:0] max_key_size;
        logic        utf8_mode;
    } t_cfg;

    // one pending group of results: a single byte or a six-byte escape
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  chr;
        logic [19:0] five;
        logic        last;
        t_status     status;
        logic [15:0] size;
    } t_desc;

    function automatic logic usable_ascii(input logic [7:0] b);
        return (b == CH_UNDERSCORE) || (b inside {[CH_ZERO:CH_NINE]}) ||
               (b inside {[CH_UPPER_A:CH_UPPER_Z]}) ||
               (b inside {[CH_LOWER_A:CH_LOWER_Z]});
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'b0, nib};
        end
        return CH_LOWER_A + {4'b0, nib - 4'd10};
    endfunction

    // byte idx of the escape: '@' then five hex digits, high first
    function automatic logic [7:0] esc_byte(input logic [19:0] five,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        case (idx)
            IDX_W'(0): r = CH_AT;
            IDX_W'(1): r = hex_char(five[19:16]);
            IDX_W'(2): r = hex_char(five[15:12]);
            IDX_W'(3): r = hex_char(five[11:8]);
            IDX_W'(4): r = hex_char(five[7:4]);
            IDX_W'(5): r = hex_char(five[3:0]);
            default:   r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/une_in_if.sv @@
// ----------------------------------------------------------------------------
// une_in_if
// Request channel carrying raw name bytes.
// ----------------------------------------------------------------------------
interface une_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
    modport monitor (input valid, input in_byte, input in_last, input ready);
endinterface

@@ rtl/une_out_if.sv @@
// ----------------------------------------------------------------------------
// une_out_if
// Request channel carrying encoded name bytes with status and size.
// ----------------------------------------------------------------------------
interface une_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        out_last;
    logic [1:0]  status;
    logic [15:0] encoded_size;

    modport source (output valid, output out_char, output out_last,
                    output status, output encoded_size, input ready);
    modport sink   (input valid, input out_char, input out_last,
                    input status, input encoded_size, output ready);
    modport monitor (input valid, input out_char, input out_last,
                     input status, input encoded_size, input ready);
endinterface

@@ rtl/utf8_name_hex_escaper_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_name_hex_escaper_unit
// Escapes name bytes into a key-safe form with '@' and five hex digits.
// ----------------------------------------------------------------------------
// Bytes of a name enter on i_in, in_last marking the final byte. Encoded
// bytes leave on o_out with status and the running encoded size; out_last
// marks the final result of the name. Letters, digits and underscore (not
// in first position) pass as one result; any other character yields six.
// A result byte passes the result group register, then the output register.
// While o_out does not stall, a pass-through byte sustains one request per
// cycle; an escape holds the input while the output register drains it,
// one byte per cycle. Bytes in the middle of a UTF-8 sequence give no result.
// When o_out stalls the output register holds its byte, one result group
// waits behind it, and i_in drops ready once both are full.
// Reset clears the name state and both registers; max_key_size returns to
// 4096 and utf8_mode to 1. APB holds max_key_size at 0x0, utf8_mode at 0x4.
// The user must write registers only while idle; the block does not check.
// ----------------------------------------------------------------------------
module utf8_name_hex_escaper_unit
    import une_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    une_in_if.sink      i_in,
    une_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg  r_cfg;
    t_desc desc;
    logic  desc_done;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_key_size <= MAX_KEY_SIZE_RST;
            r_cfg.utf8_mode    <= UTF8_MODE_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_MAX_KEY_SIZE: r_cfg.max_key_size <= pwdata[16:0];
                REG_UTF8_MODE:    r_cfg.utf8_mode    <= pwdata[0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAX_KEY_SIZE: prdata = {15'd0, r_cfg.max_key_size};
            REG_UTF8_MODE:    prdata = {31'd0, r_cfg.utf8_mode};
            default:          prdata = 32'd0;
        endcase
    end

    une_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .i_desc_done (desc_done),
        .o_desc      (desc)
    );

    une_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (desc),
        .o_desc_done (desc_done),
        .o_out       (o_out)
    );

endmodule

@@ rtl/une_decode.sv @@
// ----------------------------------------------------------------------------
// une_decode
// Per-name state, UTF-8 decode and size check; holds one result group.
// ----------------------------------------------------------------------------
module une_decode
    import une_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    une_in_if.sink     i_in,
    input  logic       i_desc_done,
    output t_desc      o_desc
);

    logic        r_at_start, n_at_start;
    logic [1:0]  r_pend, n_pend;
    logic [20:0] r_acc, n_acc;
    logic [15:0] r_cnt, n_cnt;
    logic        r_drop, n_drop;
    t_desc       r_desc, n_desc;

    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic [1:0]  pend_dec;
    logic [20:0] acc_shift;
    logic [19:0] cp_five;
    logic [2:0]  len;
    logic [7:0]  init;
    logic        stray;
    logic        pass;
    logic [17:0] need_sum;
    logic        too_long;

    assign i_in.ready = !r_desc.valid || i_desc_done;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign last       = i_in.in_last;
    assign o_desc     = r_desc;

    assign pend_dec  = r_pend - 2'd1;
    assign acc_shift = {r_acc[14:0], b[5:0]};
    assign cp_five   = (acc_shift > 21'hFFFFF) ? {3'd0, acc_shift[20:4]}
                                               : acc_shift[19:0];

    always_comb begin
        len   = 3'd1;
        init  = b;
        stray = 1'b0;
        if (i_cfg.utf8_mode) begin
            if (b < 8'h80) begin
                len = 3'd1;
            end else if ((b & 8'hE0) == 8'hC0) begin
                len  = 3'd2;
                init = b & 8'h1F;
            end else if ((b & 8'hF0) == 8'hE0) begin
                len  = 3'd3;
                init = b & 8'h0F;
            end else if ((b & 8'hF8) == 8'hF0) begin
                len  = 3'd4;
                init = b & 8'h07;
            end else begin
                stray = 1'b1;
            end
        end
        pass     = (len == 3'd1) && usable_ascii(b) && !((b == CH_UNDERSCORE) && r_at_start);
        need_sum = {2'b0, r_cnt} + (pass ? 18'd2 : 18'(ESC_LEN + 1));
        too_long = need_sum >= {1'b0, i_cfg.max_key_size};
    end

    always_comb begin
        n_at_start = r_at_start;
        n_pend     = r_pend;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_drop     = r_drop;
        n_desc     = r_desc;
        if (i_desc_done) begin
            n_desc.valid = 1'b0;
        end
        if (accept) begin
            n_desc.kind   = KIND_BYTE;
            n_desc.chr    = CH_NUL;
            n_desc.five   = 20'd0;
            n_desc.last   = last;
            n_desc.status = ST_OK;
            n_desc.size   = r_cnt;
            if (r_drop) begin
                if (last) begin
                    n_desc.valid  = 1'b1;
                    n_desc.status = ST_TOO_LONG;
                end
            end else if (r_pend != 2'd0) begin
                n_acc  = acc_shift;
                n_pend = pend_dec;
                if (pend_dec == 2'd0) begin
                    n_desc.valid = 1'b1;
                    n_desc.kind  = KIND_ESC;
                    n_desc.five  = cp_five;
                    n_desc.size  = r_cnt + 16'd1;
                    n_cnt        = r_cnt + 16'(ESC_LEN);
                    n_acc        = 21'd0;
                end else if (last) begin
                    n_desc.valid  = 1'b1;
                    n_desc.status = ST_TRUNCATED;
                end
            end else if (too_long) begin
                n_desc.valid  = 1'b1;
                n_desc.status = ST_TOO_LONG;
                n_drop        = !last;
            end else begin
                n_at_start = 1'b0;
                if (pass) begin
                    n_desc.valid = 1'b1;
                    n_desc.chr   = b;
                    n_desc.size  = r_cnt + 16'd1;
                    n_cnt        = r_cnt + 16'd1;
                end else if (len == 3'd1) begin
                    n_desc.valid = 1'b1;
                    n_desc.kind  = KIND_ESC;
                    n_desc.five  = stray ? 20'hFFFFF : {12'd0, b};
                    n_desc.size  = r_cnt + 16'd1;
                    n_cnt        = r_cnt + 16'(ESC_LEN);
                end else begin
                    n_pend = 2'(len - 3'd1);
                    n_acc  = {13'd0, init};
                    if (last) begin
                        n_desc.valid  = 1'b1;
                        n_desc.status = ST_TRUNCATED;
                    end
                end
            end
            // start a new name after the last byte
            if (last) begin
                n_at_start = 1'b1;
                n_pend     = 2'd0;
                n_acc      = 21'd0;
                n_cnt      = 16'd0;
                n_drop     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_pend       <= 2'd0;
            r_acc        <= 21'd0;
            r_cnt        <= 16'd0;
            r_drop       <= 1'b0;
            r_desc.valid <= 1'b0;
        end else begin
            r_at_start   <= n_at_start;
            r_pend       <= n_pend;
            r_acc        <= n_acc;
            r_cnt        <= n_cnt;
            r_drop       <= n_drop;
            r_desc.valid <= n_desc.valid;
        end
        r_desc.kind   <= n_desc.kind;
        r_desc.chr    <= n_desc.chr;
        r_desc.five   <= n_desc.five;
        r_desc.last   <= n_desc.last;
        r_desc.status <= n_desc.status;
        r_desc.size   <= n_desc.size;
    end

endmodule

@@ rtl/une_emit.sv @@
// ----------------------------------------------------------------------------
// une_emit
// Expands a result group into bytes and holds them in the output register.
// ----------------------------------------------------------------------------
module une_emit
    import une_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_desc,
    output logic       o_desc_done,
    une_out_if.source  o_out
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_char, n_char;
    logic             r_last, n_last;
    t_status          r_status, n_status;
    logic [15:0]      r_size, n_size;

    logic out_free;
    logic load;
    logic at_end;

    assign out_free    = !r_valid || o_out.ready;
    assign load        = i_desc.valid && out_free;
    assign at_end      = (i_desc.kind == KIND_BYTE) || (r_idx == IDX_W'(ESC_LEN - 1));
    assign o_desc_done = load && at_end;

    always_comb begin
        n_idx    = r_idx;
        n_valid  = r_valid && !o_out.ready;
        n_char   = r_char;
        n_last   = r_last;
        n_status = r_status;
        n_size   = r_size;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = at_end ? '0 : r_idx + IDX_W'(1);
            if (i_desc.kind == KIND_BYTE) begin
                n_char   = i_desc.chr;
                n_last   = i_desc.last;
                n_status = i_desc.status;
                n_size   = i_desc.size;
            end else begin
                n_char   = esc_byte(i_desc.five, r_idx);
                n_last   = at_end && i_desc.last;
                n_status = ST_OK;
                n_size   = i_desc.size + {{(16-IDX_W){1'b0}}, r_idx};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char   <= n_char;
        r_last   <= n_last;
        r_status <= n_status;
        r_size   <= n_size;
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_char     = r_char;
    assign o_out.out_last     = r_last;
    assign o_out.status       = r_status;
    assign o_out.encoded_size = r_size;

endmodule

@@ rtl/une_checker.sv @@
// ----------------------------------------------------------------------------
// une_checker
// Port-level checks for the name hex escaper, bound to the top level.
// ----------------------------------------------------------------------------
module une_checker
    import une_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic [1:0] i_status
);

    logic out_take;
    assign out_take = i_valid && i_ready;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result request dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result request valid after reset");

    a_escape_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && i_status == ST_OK && i_char == CH_AT
        |=> i_valid)
        else $error("escape sequence broken after '@'");

    a_escape_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_OK && i_char == CH_AT
        |-> !i_last)
        else $error("'@' marked as final result");

    a_error_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |-> i_char == CH_NUL)
        else $error("error result carries a character");

endmodule

bind utf8_name_hex_escaper_unit une_checker u_une_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_char   (o_out.out_char),
    .i_last   (o_out.out_last),
    .i_status (o_out.status)
);
